/* rtl/core/bmh_pkg.sv */
`default_nettype none

package bmh_pkg;

    // Operation codes carried in the mode field.
    localparam logic [1:0] MODE_INSERT  = 2'd0;
    localparam logic [1:0] MODE_DELETE  = 2'd1;
    localparam logic [1:0] MODE_EXTRACT = 2'd2;

    // Status codes returned with every result.
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_FULL   = 2'd1;
    localparam logic [1:0] STATUS_BADPOS = 2'd2;
    localparam logic [1:0] STATUS_EMPTY  = 2'd3;

    localparam logic signed [31:0] KEY_MIN     = 32'sh8000_0000;
    localparam logic signed [31:0] VALUE_EMPTY = -32'sd1;
    localparam logic signed [31:0] VALUE_NONE  = 32'sd0;

    typedef struct packed {
        logic        [1:0]  mode;
        logic signed [31:0] key;
        logic        [6:0]  position;
    } heap_req_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic        [1:0]  status;
        logic        [7:0]  count;
    } heap_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_ROOT_RD,
        S_ROOT_CAP,
        S_DN_RD,
        S_DN_CMP,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

/* rtl/core/binary_min_heap.sv */
`default_nettype none

// Binary min-heap of signed 32-bit keys, up to CAPACITY entries, held in one
// synchronous memory with one write port and two registered read ports. Each
// request transaction carries an insert, a delete at a heap position or an
// extract-min, and yields exactly one response transaction with the extracted
// key (or zero, or -1 on an empty heap), a status code and the key count left
// afterwards. One request is worked at a time; its cost is set by the
// read-compare-write loop around the memory, run once per heap level. An
// insert lets the key climb toward the root. An extract moves the last key to
// the root and lets it sink toward a leaf. A delete takes both walks in turn,
// and rejected requests skip the walk altogether. After the result is handed
// over, the block returns to idle before the next request is taken. The
// response sits in an output register, so a new request is taken while an
// earlier response still waits. Heap memory needs no clearing after reset:
// only data read from entries below the count is ever used.
module binary_min_heap #(
    parameter int CAPACITY = 128
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire bmh_pkg::heap_req_t  req,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output bmh_pkg::heap_rsp_t       rsp
);

    import bmh_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic               res_valid;
    logic               res_ready;
    heap_rsp_t          res;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic signed [31:0] mem_wdata;
    logic [AW-1:0]      mem_raddr_a;
    logic [AW-1:0]      mem_raddr_b;
    logic signed [31:0] mem_rdata_a;
    logic signed [31:0] mem_rdata_b;

    logic               rsp_valid_reg, rsp_valid_next;
    heap_rsp_t          rsp_reg,       rsp_next;

    bmh_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr_a (mem_raddr_a),
        .mem_raddr_b (mem_raddr_b),
        .mem_rdata_a (mem_rdata_a),
        .mem_rdata_b (mem_rdata_b)
    );

    bmh_mem #(
        .DEPTH (CAPACITY)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    // The output register takes a new result whenever it is empty or its
    // current transaction completes in this same cycle.
    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (res_valid && res_ready)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

/* rtl/core/bmh_mem.sv */
`default_nettype none

module bmh_mem #(
    parameter int DEPTH = 128
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic signed [31:0]               wdata,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr_b,
    output logic signed [31:0]                    rdata_a,
    output logic signed [31:0]                    rdata_b
);

    logic signed [31:0] store [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store[waddr] <= wdata;
        end
    end

    // Both read ports are registered; data appears in the cycle after the address.
    always_ff @(posedge clk)
    begin
        rdata_a <= store[raddr_a];
        rdata_b <= store[raddr_b];
    end

endmodule

`default_nettype wire

/* rtl/core/bmh_ctrl.sv */
`default_nettype none

module bmh_ctrl #(
    parameter int CAPACITY = 128
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_ready,
    input  wire bmh_pkg::heap_req_t            req,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output bmh_pkg::heap_rsp_t                 res,
    output logic                               mem_we,
    output logic [$clog2(CAPACITY)-1:0]        mem_waddr,
    output logic signed [31:0]                 mem_wdata,
    output logic [$clog2(CAPACITY)-1:0]        mem_raddr_a,
    output logic [$clog2(CAPACITY)-1:0]        mem_raddr_b,
    input  wire logic signed [31:0]            mem_rdata_a,
    input  wire logic signed [31:0]            mem_rdata_b
);

    import bmh_pkg::*;

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int CHW = AW + 2;
    localparam int PW  = (CW > 7) ? CW : 7;

    state_t             state_reg,  state_next;
    logic [CW-1:0]      count_reg,  count_next;
    logic [AW-1:0]      idx_reg,    idx_next;
    logic signed [31:0] val_reg,    val_next;
    logic signed [31:0] value_reg,  value_next;
    logic [1:0]         status_reg, status_next;
    logic [1:0]         mode_reg,   mode_next;

    logic               accept;
    logic [AW-1:0]      parent_idx;
    logic [CHW-1:0]     left_idx;
    logic [CHW-1:0]     right_idx;
    logic               left_ok;
    logic               right_ok;
    logic               take_left;
    logic signed [31:0] best_val;
    logic               take_right;
    logic               parent_gt;
    logic               full;
    logic               bad_pos;
    logic               is_delete;

    assign accept     = req_valid && req_ready;
    assign parent_idx = (idx_reg - 1'b1) >> 1;
    assign left_idx   = {1'b0, idx_reg, 1'b1};
    assign right_idx  = left_idx + 1'b1;
    assign left_ok    = left_idx < CHW'(count_reg);
    assign right_ok   = right_idx < CHW'(count_reg);

    // Ties prefer the left child; the right child wins only when strictly smaller.
    assign take_left  = left_ok && (mem_rdata_a < val_reg);
    assign best_val   = take_left ? mem_rdata_a : val_reg;
    assign take_right = right_ok && (mem_rdata_b < best_val);
    assign parent_gt  = mem_rdata_a > val_reg;

    assign full      = count_reg == CW'(CAPACITY);
    assign bad_pos   = PW'(req.position) >= PW'(count_reg);
    assign is_delete = mode_reg == MODE_DELETE;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.mode)
                        MODE_INSERT:  state_next = full ? S_DONE : S_UP_RD;
                        MODE_DELETE:  state_next = bad_pos ? S_DONE : S_UP_RD;
                        MODE_EXTRACT: state_next = (count_reg == '0) ? S_DONE : S_ROOT_RD;
                        default:      state_next = S_DONE;
                    endcase
                end
            end
            S_UP_RD:
            begin
                if (idx_reg == '0)
                begin
                    state_next = is_delete ? S_ROOT_RD : S_DONE;
                end
                else
                begin
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (parent_gt)
                begin
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = is_delete ? S_ROOT_RD : S_DONE;
                end
            end
            S_ROOT_RD:  state_next = S_ROOT_CAP;
            S_ROOT_CAP: state_next = (count_reg == '0) ? S_DONE : S_DN_RD;
            S_DN_RD:    state_next = left_ok ? S_DN_CMP : S_DONE;
            S_DN_CMP:   state_next = (take_left || take_right) ? S_DN_RD : S_DONE;
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath registers.
    always_comb
    begin
        count_next  = count_reg;
        idx_next    = idx_reg;
        val_next    = val_reg;
        value_next  = value_reg;
        status_next = status_reg;
        mode_next   = mode_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next   = req.mode;
                    value_next  = VALUE_NONE;
                    status_next = STATUS_OK;
                    case (req.mode)
                        MODE_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                idx_next   = AW'(count_reg);
                                val_next   = req.key;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (bad_pos)
                            begin
                                status_next = STATUS_BADPOS;
                            end
                            else
                            begin
                                idx_next = AW'(req.position);
                                val_next = KEY_MIN;
                            end
                        end
                        MODE_EXTRACT:
                        begin
                            if (count_reg == '0)
                            begin
                                value_next  = VALUE_EMPTY;
                                status_next = STATUS_EMPTY;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_UP_CMP:
            begin
                if (parent_gt)
                begin
                    idx_next = parent_idx;
                end
            end
            S_ROOT_RD:
            begin
                count_next = count_reg - 1'b1;
            end
            S_ROOT_CAP:
            begin
                if (!is_delete)
                begin
                    value_next = mem_rdata_a;
                end
                val_next = mem_rdata_b;
                idx_next = '0;
            end
            S_DN_CMP:
            begin
                if (take_right)
                begin
                    idx_next = right_idx[AW-1:0];
                end
                else if (take_left)
                begin
                    idx_next = left_idx[AW-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    // Outputs and memory port control.
    always_comb
    begin
        req_ready   = state_reg == S_IDLE;
        res_valid   = state_reg == S_DONE;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg;
        mem_wdata   = val_reg;
        mem_raddr_a = parent_idx;
        mem_raddr_b = right_idx[AW-1:0];
        case (state_reg)
            S_UP_RD:
            begin
                mem_we = idx_reg == '0;
            end
            S_UP_CMP:
            begin
                mem_we    = 1'b1;
                mem_wdata = parent_gt ? mem_rdata_a : val_reg;
            end
            S_ROOT_RD:
            begin
                mem_raddr_a = '0;
                mem_raddr_b = AW'(count_reg - 1'b1);
            end
            S_DN_RD:
            begin
                mem_raddr_a = left_idx[AW-1:0];
                mem_we      = !left_ok;
            end
            S_DN_CMP:
            begin
                mem_we = 1'b1;
                if (take_right)
                begin
                    mem_wdata = mem_rdata_b;
                end
                else if (take_left)
                begin
                    mem_wdata = mem_rdata_a;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res.value  = value_reg;
    assign res.status = status_reg;
    assign res.count  = 8'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        val_reg    <= val_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        mode_reg   <= mode_next;
    end

endmodule

`default_nettype wire
